[rtl/sirt_pkg.sv]
package sirt_pkg;

	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 64;
	localparam int SYM_W     = 8;
	localparam int SYM_COUNT = 16;
	localparam int LEN_W     = 5;
	localparam int DIGIT_W   = 4;
	localparam int STEP_BITS = 8;

	localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		REG_SYMBOLS_LOW,
		REG_SYMBOLS_HIGH,
		REG_ALPHABET_LENGTH
	} reg_t;

	typedef struct packed {
		logic [SYM_COUNT*SYM_W-1:0] symbols;
		logic [LEN_W-1:0]           length;
		logic                       ok;
	} cfg_t;

endpackage

[rtl/sirt_cfg.sv]
module sirt_cfg #(
	parameter int MAX_RADIX = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sirt_pkg::ADDR_W-1:0]      paddr,
	input  logic [sirt_pkg::DATA_W-1:0]      pwdata,
	output logic [sirt_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	output sirt_pkg::cfg_t                   cfg
);

	logic [sirt_pkg::DATA_W-1:0] sym_lo_q;
	logic [sirt_pkg::DATA_W-1:0] sym_hi_q;
	logic [sirt_pkg::LEN_W-1:0]  len_q;
	sirt_pkg::reg_t              reg_sel;
	logic                        wr_en;
	logic [sirt_pkg::SYM_COUNT*sirt_pkg::SYM_W-1:0] syms;
	logic                        bad;

	assign pready  = 1'b1;
	assign reg_sel = sirt_pkg::reg_t'(paddr[sirt_pkg::ADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite;
	assign syms    = {sym_hi_q, sym_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_lo_q <= '0;
			sym_hi_q <= '0;
			len_q    <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				sirt_pkg::REG_SYMBOLS_LOW:     sym_lo_q <= pwdata;
				sirt_pkg::REG_SYMBOLS_HIGH:    sym_hi_q <= pwdata;
				sirt_pkg::REG_ALPHABET_LENGTH: len_q    <= pwdata[sirt_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			sirt_pkg::REG_SYMBOLS_LOW:     prdata = sym_lo_q;
			sirt_pkg::REG_SYMBOLS_HIGH:    prdata = sym_hi_q;
			sirt_pkg::REG_ALPHABET_LENGTH: prdata = sirt_pkg::DATA_W'(len_q);
			default:                       prdata = '0;
		endcase
	end

	// checks the alphabet length range, bars '+' and '-' and compares the symbols in use pairwise
	always_comb begin
		bad = (len_q < sirt_pkg::LEN_W'(2)) || (len_q > sirt_pkg::LEN_W'(MAX_RADIX));
		for (int i = 0; i < sirt_pkg::SYM_COUNT; i++) begin
			if (sirt_pkg::LEN_W'(i) < len_q) begin
				if (syms[i*sirt_pkg::SYM_W +: sirt_pkg::SYM_W] == sirt_pkg::CHAR_PLUS ||
				    syms[i*sirt_pkg::SYM_W +: sirt_pkg::SYM_W] == sirt_pkg::CHAR_MINUS) begin
					bad = 1'b1;
				end
				for (int j = i + 1; j < sirt_pkg::SYM_COUNT; j++) begin
					if (sirt_pkg::LEN_W'(j) < len_q &&
					    syms[i*sirt_pkg::SYM_W +: sirt_pkg::SYM_W] ==
					    syms[j*sirt_pkg::SYM_W +: sirt_pkg::SYM_W]) begin
						bad = 1'b1;
					end
				end
			end
		end
	end

	assign cfg.symbols = syms;
	assign cfg.length  = len_q;
	assign cfg.ok      = !bad;

endmodule

[rtl/sirt_div.sv]
module sirt_div #(
	parameter int WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [WIDTH-1:0]              dividend,
	input  logic [sirt_pkg::LEN_W-1:0]    divisor,
	output logic                          done,
	output logic [WIDTH-1:0]              quotient,
	output logic [sirt_pkg::DIGIT_W-1:0]  remainder
);

	localparam int STEP   = sirt_pkg::STEP_BITS;
	localparam int CHUNKS = (WIDTH + STEP - 1) / STEP;
	localparam int PAD    = CHUNKS * STEP;
	localparam int CNT_W  = $clog2(CHUNKS + 1);

	logic [PAD-1:0]                 quo_q;
	logic [PAD-1:0]                 quo_nxt;
	logic [sirt_pkg::LEN_W-1:0]     rem_q;
	logic [sirt_pkg::LEN_W:0]       rem_nxt;
	logic [CNT_W-1:0]               cnt_q;
	logic                           done_q;

	// restoring long division, one byte of quotient bits per cycle
	always_comb begin
		rem_nxt = {1'b0, rem_q};
		quo_nxt = quo_q;
		for (int i = 0; i < STEP; i++) begin
			rem_nxt = {rem_nxt[sirt_pkg::LEN_W-1:0], quo_nxt[PAD-1]};
			quo_nxt = {quo_nxt[PAD-2:0], 1'b0};
			if (rem_nxt >= {1'b0, divisor}) begin
				rem_nxt    = rem_nxt - {1'b0, divisor};
				quo_nxt[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			quo_q  <= PAD'(dividend);
			rem_q  <= '0;
			cnt_q  <= CNT_W'(CHUNKS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			quo_q  <= quo_nxt;
			rem_q  <= rem_nxt[sirt_pkg::LEN_W-1:0];
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q[WIDTH-1:0];
	assign remainder = rem_q[sirt_pkg::DIGIT_W-1:0];

endmodule

[rtl/signed_integer_to_radix_text_core.sv]
// Converts a signed two's-complement value into text in the radix set by the
// configured alphabet (radix = alphabet_length, symbols in symbols_low/high).
// A negative value gives a leading '-', then the digits of the magnitude come
// most significant first, one character per output beat, last high on the
// final one; zero gives symbol 0, and an invalid alphabet gives no beats.
// While a value is converted the input is stalled. After the accept beat the
// check state tests the alphabet, then each digit runs through the shared
// divider, which retires eight quotient bits a cycle; each digit character
// then needs a digit buffer read and then the beat, a leading minus sign
// needs only the beat, and an output stall holds the beat. An invalid
// alphabet returns to idle after the check state.
module signed_integer_to_radix_text_core #(
	parameter int MAX_RADIX  = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sirt_pkg::ADDR_W-1:0]       paddr,
	input  logic [sirt_pkg::DATA_W-1:0]       pwdata,
	output logic [sirt_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [VALUE_BITS-1:0]      value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sirt_pkg::SYM_W-1:0]        character,
	output logic                              last
);

	localparam int IDX_W = $clog2(VALUE_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_FETCH,
		ST_SHOW
	} state_t;

	state_t                        state_q;
	logic                          neg_q;
	logic                          sign_q;
	logic [VALUE_BITS-1:0]         mag_q;
	logic [IDX_W-1:0]              cnt_q;
	logic [IDX_W-1:0]              ptr_q;
	logic [sirt_pkg::SYM_W-1:0]    digit_mem [VALUE_BITS];
	logic [sirt_pkg::SYM_W-1:0]    rdata_q;

	sirt_pkg::cfg_t                cfg;
	logic                          div_start;
	logic                          div_done;
	logic [VALUE_BITS-1:0]         div_operand;
	logic [VALUE_BITS-1:0]         div_quot;
	logic [sirt_pkg::DIGIT_W-1:0]  div_rem;
	logic                          more;
	logic                          mem_we;
	logic [sirt_pkg::SYM_W-1:0]    digit_sym;
	logic [VALUE_BITS-1:0]         value_u;

	sirt_cfg #(
		.MAX_RADIX (MAX_RADIX)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sirt_div #(
		.WIDTH (VALUE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_operand),
		.divisor   (cfg.length),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign value_u     = unsigned'(value);
	assign more        = (div_quot != '0) && (cnt_q != IDX_W'(VALUE_BITS - 1));
	assign div_start   = (state_q == ST_CHECK && cfg.ok) ||
	                     (state_q == ST_DIVIDE && div_done && more);
	assign div_operand = (state_q == ST_CHECK) ? mag_q : div_quot;
	assign mem_we      = (state_q == ST_DIVIDE) && div_done;
	assign digit_sym   = cfg.symbols[{div_rem, 3'b000} +: sirt_pkg::SYM_W];

	// digit buffer, least significant digit at index 0
	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_mem[cnt_q] <= digit_sym;
		end
		rdata_q <= digit_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
			sign_q  <= 1'b0;
			mag_q   <= '0;
			cnt_q   <= '0;
			ptr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						neg_q   <= value_u[VALUE_BITS-1];
						mag_q   <= value_u[VALUE_BITS-1] ? ('0 - value_u) : value_u;
						cnt_q   <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= cfg.ok ? ST_DIVIDE : ST_IDLE;
				end
				ST_DIVIDE: begin
					if (div_done) begin
						ptr_q <= cnt_q;
						if (more) begin
							cnt_q <= cnt_q + IDX_W'(1);
						end else begin
							sign_q  <= neg_q;
							state_q <= neg_q ? ST_SHOW : ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (!out_stall) begin
						if (sign_q) begin
							sign_q  <= 1'b0;
							state_q <= ST_FETCH;
						end else if (ptr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q   <= ptr_q - IDX_W'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_SHOW);
	assign character = sign_q ? sirt_pkg::CHAR_MINUS : rdata_q;
	assign last      = !sign_q && (ptr_q == '0);

endmodule

[rtl/sirt_checker.sv]
module sirt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [sirt_pkg::SYM_W-1:0]    character,
	input logic                          last
);

	// a beat is accepted only while idle, so the block goes busy right after
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	a_out_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("output beat while input is open");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid)
		else $error("output continues after last beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(character) && $stable(last))
		else $error("stalled output beat changed");

	a_last_not_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> character != sirt_pkg::CHAR_MINUS)
		else $error("text ends with a minus sign");

endmodule

bind signed_integer_to_radix_text_core sirt_checker u_sirt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.character (character),
	.last      (last)
);
